### rtl/ssbt_pkg.sv
// shared codes for the subresource state barrier tracker
package ssbt_pkg;

	// item operation codes
	localparam logic [1:0] OP_DEFINE = 2'd0;
	localparam logic [1:0] OP_USE    = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	// fixed field widths
	localparam int STATE_W = 32;
	localparam int PASS_W  = 16;
	localparam int QUEUE_W = 2;
	localparam int RID_W   = 8;
	localparam int SUB16_W = 16;
	localparam int BRES_W  = 6;
	localparam int BSUB_W  = 4;

endpackage

### rtl/subresource_state_barrier_tracker.sv
// subresource state barrier tracker top level
//
// Command interface: an item is taken at a clock edge where start is high and
// busy is low. Items are define (register the next resource id, fill its
// subresource entries with an initial state), use (one subresource or all,
// compare against a target state, emit transitions, store the target) and
// clear (forget every resource). Transitions leave on the barrier ports,
// each for exactly one cycle with result_valid high; last marks the final
// transition of a use. The receiver cannot stall, results are never held.
// Clear, ignored uses and a define on a full table leave busy low. A whole
// use makes two sweeps over the resource's entries through the
// single read port of the state memory (a uniformity scan, then a
// read-compare-write sweep). Each result is registered from the
// registered read data of its entry. Reset empties the table (defined count
// zero); memory contents are never relied on before a define writes them,
// so no clearing pass is run.
module subresource_state_barrier_tracker #(
	parameter int MAX_RESOURCES    = 64,
	parameter int MAX_SUBRESOURCES = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        op,
	input  logic [ssbt_pkg::RID_W-1:0]        resource_id,
	input  logic [ssbt_pkg::SUB16_W-1:0]      subresource,
	input  logic                              all_subresources,
	input  logic [ssbt_pkg::STATE_W-1:0]      usage_state,
	input  logic [ssbt_pkg::SUB16_W-1:0]      subresource_count,
	input  logic [ssbt_pkg::PASS_W-1:0]       pass_number,
	input  logic [ssbt_pkg::QUEUE_W-1:0]      queue_kind,
	output logic                              result_valid,
	output logic [ssbt_pkg::PASS_W-1:0]       barrier_pass,
	output logic [ssbt_pkg::QUEUE_W-1:0]      barrier_queue,
	output logic [ssbt_pkg::BRES_W-1:0]       barrier_resource,
	output logic [ssbt_pkg::BSUB_W-1:0]       barrier_subresource,
	output logic                              barrier_whole,
	output logic [ssbt_pkg::STATE_W-1:0]      state_before,
	output logic [ssbt_pkg::STATE_W-1:0]      state_after,
	output logic                              last
);

	localparam int ID_W   = MAX_RESOURCES > 1 ? $clog2(MAX_RESOURCES) : 1;
	localparam int DC_W   = $clog2(MAX_RESOURCES + 1);
	localparam int SUB_W  = MAX_SUBRESOURCES > 1 ? $clog2(MAX_SUBRESOURCES) : 1;
	localparam int CNT_W  = $clog2(MAX_SUBRESOURCES + 1);
	localparam int ENTRIES = MAX_RESOURCES * MAX_SUBRESOURCES;
	localparam int AW     = $clog2(ENTRIES > 1 ? ENTRIES : 2);
	localparam int CAW    = $clog2(MAX_RESOURCES > 1 ? MAX_RESOURCES : 2);

	// sequencer states
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DFILL  = 3'd1;
	localparam logic [2:0] S_UCNT   = 3'd2;
	localparam logic [2:0] S_SINGLE = 3'd3;
	localparam logic [2:0] S_SCAN   = 3'd4;
	localparam logic [2:0] S_SWEEP  = 3'd5;

	logic [2:0]                   state_q;
	logic [DC_W-1:0]              defined_q;
	logic [CNT_W-1:0]             cnt_q;
	logic [CNT_W-1:0]             wr_ptr_q;
	logic [CNT_W-1:0]             rd_ptr_q;
	logic [SUB_W-1:0]             sub_q;
	logic [ssbt_pkg::RID_W-1:0]   rid_q;
	logic [ssbt_pkg::SUB16_W-1:0] sub_in_q;
	logic                         whole_q;
	logic [ssbt_pkg::STATE_W-1:0] target_q;
	logic [ssbt_pkg::PASS_W-1:0]  pass_q;
	logic [ssbt_pkg::QUEUE_W-1:0] queue_q;
	logic [ssbt_pkg::STATE_W-1:0] st0_q;
	logic                         uniform_q;
	logic                         any_diff_q;
	logic [SUB_W-1:0]             last_diff_q;
	logic                         rd_v_s1;
	logic [SUB_W-1:0]             rd_idx_s1;

	logic                         accept;
	logic                         use_ok;
	logic                         def_ok;
	logic [ssbt_pkg::SUB16_W-1:0] def_cnt16;
	logic [CNT_W-1:0]             cnt_rd;
	logic [ssbt_pkg::SUB16_W-1:0] cnt_m1;
	logic [ssbt_pkg::SUB16_W-1:0] clamp16;
	logic                         rd_en;
	logic [CNT_W-1:0]             rd_sub;
	logic [ssbt_pkg::STATE_W-1:0] st_rdata;
	logic                         st_we;
	logic [AW-1:0]                st_waddr;
	logic [AW-1:0]                st_raddr;
	logic                         last_in;
	logic                         scan_end;
	logic [ssbt_pkg::RID_W:0]     rid_ext;
	logic [ssbt_pkg::RID_W:0]     dc_ext;

	// flat entry address of one subresource
	function automatic logic [AW-1:0] entry_addr(input logic [ID_W-1:0] id,
			input logic [SUB_W-1:0] idx);
		entry_addr = AW'(id) * AW'(MAX_SUBRESOURCES) + AW'(idx);
	endfunction

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	// acceptance checks
	assign rid_ext = (ssbt_pkg::RID_W + 1)'(resource_id);
	assign dc_ext  = (ssbt_pkg::RID_W + 1)'(defined_q);
	assign use_ok  = (op == ssbt_pkg::OP_USE) && (rid_ext < dc_ext);
	assign def_ok  = (op == ssbt_pkg::OP_DEFINE) && (defined_q < DC_W'(MAX_RESOURCES));

	// define count: zero means one, saturate at the maximum
	always_comb begin
		if (subresource_count == '0) begin
			def_cnt16 = ssbt_pkg::SUB16_W'(1);
		end else if (subresource_count > ssbt_pkg::SUB16_W'(MAX_SUBRESOURCES)) begin
			def_cnt16 = ssbt_pkg::SUB16_W'(MAX_SUBRESOURCES);
		end else begin
			def_cnt16 = subresource_count;
		end
	end

	// single index clamp against the stored count
	assign cnt_m1  = ssbt_pkg::SUB16_W'(cnt_rd) - ssbt_pkg::SUB16_W'(1);
	assign clamp16 = (sub_in_q > cnt_m1) ? cnt_m1 : sub_in_q;

	assign last_in  = rd_v_s1 && (CNT_W'(rd_idx_s1) == cnt_q - CNT_W'(1));
	assign scan_end = (state_q == S_SCAN) && last_in;

	// state memory read issue
	always_comb begin
		rd_en  = 1'b0;
		rd_sub = '0;
		case (state_q)
			S_UCNT: begin
				rd_en  = 1'b1;
				rd_sub = whole_q ? '0 : CNT_W'(clamp16);
			end
			S_SCAN: begin
				if (scan_end) begin
					rd_en  = 1'b1;
					rd_sub = '0;
				end else if (rd_ptr_q < cnt_q) begin
					rd_en  = 1'b1;
					rd_sub = rd_ptr_q;
				end
			end
			S_SWEEP: begin
				if (rd_ptr_q < cnt_q) begin
					rd_en  = 1'b1;
					rd_sub = rd_ptr_q;
				end
			end
			default: begin
				rd_en  = 1'b0;
				rd_sub = '0;
			end
		endcase
	end

	assign st_raddr = entry_addr(rid_q[ID_W-1:0], rd_sub[SUB_W-1:0]);

	// state memory write port
	always_comb begin
		st_we    = 1'b0;
		st_waddr = '0;
		case (state_q)
			S_DFILL: begin
				st_we    = 1'b1;
				st_waddr = entry_addr(defined_q[ID_W-1:0], wr_ptr_q[SUB_W-1:0]);
			end
			S_SINGLE: begin
				st_we    = 1'b1;
				st_waddr = entry_addr(rid_q[ID_W-1:0], sub_q);
			end
			S_SWEEP: begin
				st_we    = rd_v_s1;
				st_waddr = entry_addr(rid_q[ID_W-1:0], rd_idx_s1);
			end
			default: begin
				st_we    = 1'b0;
				st_waddr = '0;
			end
		endcase
	end

	ssbt_ram #(
		.WIDTH (ssbt_pkg::STATE_W),
		.DEPTH (ENTRIES)
	) u_state_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (target_q),
		.re    (rd_en),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	ssbt_ram #(
		.WIDTH (CNT_W),
		.DEPTH (MAX_RESOURCES)
	) u_count_ram (
		.clk   (clk),
		.we    (accept && def_ok),
		.waddr (CAW'(defined_q[ID_W-1:0])),
		.wdata (CNT_W'(def_cnt16)),
		.re    (accept && use_ok),
		.raddr (CAW'(resource_id[ID_W-1:0])),
		.rdata (cnt_rd)
	);

	// item latch
	always_ff @(posedge clk) begin
		if (accept) begin
			rid_q    <= resource_id;
			sub_in_q <= subresource;
			whole_q  <= all_subresources;
			target_q <= usage_state;
			pass_q   <= pass_number;
			queue_q  <= queue_kind;
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			defined_q <= '0;
			rd_v_s1   <= 1'b0;
		end else begin
			rd_v_s1 <= rd_en;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (op == ssbt_pkg::OP_CLEAR) begin
							defined_q <= '0;
						end else if (def_ok) begin
							state_q <= S_DFILL;
						end else if (use_ok) begin
							state_q <= S_UCNT;
						end
					end
				end
				S_DFILL: begin
					if (wr_ptr_q == cnt_q - CNT_W'(1)) begin
						defined_q <= defined_q + DC_W'(1);
						state_q   <= S_IDLE;
					end
				end
				S_UCNT: begin
					state_q <= whole_q ? S_SCAN : S_SINGLE;
				end
				S_SINGLE: begin
					state_q <= S_IDLE;
				end
				S_SCAN: begin
					if (scan_end) begin
						state_q <= S_SWEEP;
					end
				end
				S_SWEEP: begin
					if (last_in) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// counters, scan results and working registers
	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_sub[SUB_W-1:0];
		if (accept && def_ok) begin
			cnt_q    <= CNT_W'(def_cnt16);
			wr_ptr_q <= '0;
		end
		if (state_q == S_DFILL) begin
			wr_ptr_q <= wr_ptr_q + CNT_W'(1);
		end
		if (state_q == S_UCNT) begin
			cnt_q      <= cnt_rd;
			sub_q      <= clamp16[SUB_W-1:0];
			rd_ptr_q   <= CNT_W'(1);
			any_diff_q <= 1'b0;
		end else if (scan_end) begin
			rd_ptr_q <= CNT_W'(1);
		end else if (rd_en) begin
			rd_ptr_q <= rd_ptr_q + CNT_W'(1);
		end
		// uniformity and last differing entry
		if ((state_q == S_SCAN) && rd_v_s1) begin
			if (rd_idx_s1 == '0) begin
				st0_q     <= st_rdata;
				uniform_q <= 1'b1;
			end else if (st_rdata != st0_q) begin
				uniform_q <= 1'b0;
			end
			if (st_rdata != target_q) begin
				any_diff_q  <= 1'b1;
				last_diff_q <= rd_idx_s1;
			end
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			if ((state_q == S_SINGLE) && (st_rdata != target_q)) begin
				result_valid <= 1'b1;
			end else if ((state_q == S_SWEEP) && rd_v_s1) begin
				if (uniform_q) begin
					result_valid <= (rd_idx_s1 == '0) && any_diff_q;
				end else begin
					result_valid <= (st_rdata != target_q);
				end
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		barrier_pass     <= pass_q;
		barrier_queue    <= queue_q;
		barrier_resource <= rid_q[ssbt_pkg::BRES_W-1:0];
		state_before     <= st_rdata;
		state_after      <= target_q;
		if (state_q == S_SINGLE) begin
			barrier_subresource <= ssbt_pkg::BSUB_W'(8'(sub_q));
			barrier_whole       <= 1'b0;
			last                <= 1'b1;
		end else if (uniform_q) begin
			barrier_subresource <= '0;
			barrier_whole       <= 1'b1;
			last                <= 1'b1;
		end else begin
			barrier_subresource <= ssbt_pkg::BSUB_W'(8'(rd_idx_s1));
			barrier_whole       <= 1'b0;
			last                <= (rd_idx_s1 == last_diff_q);
		end
	end

endmodule

### rtl/ssbt_ram.sv
// generic simple dual port ram with registered read
module ssbt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic                             re,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### tb/sv/tb.sv
// testbench for the subresource state barrier tracker: directed table, then random items
`timescale 1ns / 100ps

module tb;

	localparam int MAX_RES     = 64;
	localparam int MAX_SUB     = 16;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_WAIT  = 50;
	localparam int DIR_N       = 23;
	localparam int USE_MODEL   = -1;

	// op code with no meaning, the block leaves its table alone
	localparam logic [1:0] OP_IDLE = 2'd3;

	typedef struct packed {
		logic [1:0]                   op;
		logic [ssbt_pkg::RID_W-1:0]   rid;
		logic [ssbt_pkg::SUB16_W-1:0] sub;
		logic                         whole;
		logic [ssbt_pkg::STATE_W-1:0] st;
		logic [ssbt_pkg::SUB16_W-1:0] cnt;
		logic [ssbt_pkg::PASS_W-1:0]  pass;
		logic [ssbt_pkg::QUEUE_W-1:0] queue;
	} item_t;

	typedef struct packed {
		logic [ssbt_pkg::PASS_W-1:0]  pass;
		logic [ssbt_pkg::QUEUE_W-1:0] queue;
		logic [ssbt_pkg::BRES_W-1:0]  res;
		logic [ssbt_pkg::BSUB_W-1:0]  sub;
		logic                         whole;
		logic [ssbt_pkg::STATE_W-1:0] st_old;
		logic [ssbt_pkg::STATE_W-1:0] st_new;
		logic                         last;
	} transition_t;

	// nexp: USE_MODEL, or the number of typed-in transitions (0 or 1)
	typedef struct packed {
		item_t       it;
		int          nexp;
		transition_t tr;
	} dir_row_t;

	localparam transition_t NO_T = '0;

	logic                          clk;
	logic                          arst_n;
	logic                          start;
	logic                          busy;
	logic [1:0]                    op;
	logic [ssbt_pkg::RID_W-1:0]    resource_id;
	logic [ssbt_pkg::SUB16_W-1:0]  subresource;
	logic                          all_subresources;
	logic [ssbt_pkg::STATE_W-1:0]  usage_state;
	logic [ssbt_pkg::SUB16_W-1:0]  subresource_count;
	logic [ssbt_pkg::PASS_W-1:0]   pass_number;
	logic [ssbt_pkg::QUEUE_W-1:0]  queue_kind;
	logic                          result_valid;
	logic [ssbt_pkg::PASS_W-1:0]   barrier_pass;
	logic [ssbt_pkg::QUEUE_W-1:0]  barrier_queue;
	logic [ssbt_pkg::BRES_W-1:0]   barrier_resource;
	logic [ssbt_pkg::BSUB_W-1:0]   barrier_subresource;
	logic                          barrier_whole;
	logic [ssbt_pkg::STATE_W-1:0]  state_before;
	logic [ssbt_pkg::STATE_W-1:0]  state_after;
	logic                          last;

	// shadow copy of the usage table
	logic [ssbt_pkg::STATE_W-1:0]  usage_tab [MAX_RES][MAX_SUB];
	int                            sub_count [MAX_RES];
	int                            defined_cnt;

	transition_t                   pending_transitions [$];
	logic [ssbt_pkg::STATE_W-1:0]  state_pool [4];
	dir_row_t                      dir_tab [DIR_N];
	int                            gap_pct;
	int                            mismatches;
	int                            stall_cycles;

	subresource_state_barrier_tracker #(
		.MAX_RESOURCES    (MAX_RES),
		.MAX_SUBRESOURCES (MAX_SUB)
	) dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.start               (start),
		.busy                (busy),
		.op                  (op),
		.resource_id         (resource_id),
		.subresource         (subresource),
		.all_subresources    (all_subresources),
		.usage_state         (usage_state),
		.subresource_count   (subresource_count),
		.pass_number         (pass_number),
		.queue_kind          (queue_kind),
		.result_valid        (result_valid),
		.barrier_pass        (barrier_pass),
		.barrier_queue       (barrier_queue),
		.barrier_resource    (barrier_resource),
		.barrier_subresource (barrier_subresource),
		.barrier_whole       (barrier_whole),
		.state_before        (state_before),
		.state_after         (state_after),
		.last                (last)
	);

	initial clk = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
		end
	endtask

	// update the shadow table for one accepted item, queue the transitions it causes
	function automatic void predict_transitions(input item_t it, input bit emit);
		transition_t found [$];
		transition_t tr;
		int          n_sub;
		int          id;
		int          slot;
		int          i;
		bit          uniform;
		tr = '0;
		tr.pass = it.pass;
		tr.queue = it.queue;
		case (it.op)
			ssbt_pkg::OP_DEFINE: begin
				if (defined_cnt < MAX_RES) begin
					n_sub = (it.cnt == 0) ? 1 : (it.cnt > MAX_SUB) ? MAX_SUB : int'(it.cnt);
					sub_count[defined_cnt] = n_sub;
					for (i = 0; i < n_sub; i++) usage_tab[defined_cnt][i] = it.st;
					defined_cnt++;
				end
			end
			ssbt_pkg::OP_CLEAR: begin
				defined_cnt = 0;
			end
			ssbt_pkg::OP_USE: begin
				if (int'(it.rid) < defined_cnt) begin
					id = int'(it.rid);
					n_sub = sub_count[id];
					tr.res = id[ssbt_pkg::BRES_W-1:0];
					tr.st_new = it.st;
					if (it.whole) begin
						uniform = 1'b1;
						for (i = 1; i < n_sub; i++) begin
							if (usage_tab[id][i] != usage_tab[id][0]) uniform = 1'b0;
						end
						if (uniform) begin
							// one whole-resource transition at most
							if (usage_tab[id][0] != it.st) begin
								tr.sub = '0;
								tr.whole = 1'b1;
								tr.st_old = usage_tab[id][0];
								found = {found, tr};
							end
						end else begin
							// mixed states: one per differing entry, in index order
							for (i = 0; i < n_sub; i++) begin
								if (usage_tab[id][i] != it.st) begin
									tr.sub = i[ssbt_pkg::BSUB_W-1:0];
									tr.st_old = usage_tab[id][i];
									found = {found, tr};
								end
							end
						end
						for (i = 0; i < n_sub; i++) usage_tab[id][i] = it.st;
					end else begin
						// index past the end clamps to the last entry
						slot = (int'(it.sub) > n_sub - 1) ? n_sub - 1 : int'(it.sub);
						if (usage_tab[id][slot] != it.st) begin
							tr.sub = slot[ssbt_pkg::BSUB_W-1:0];
							tr.st_old = usage_tab[id][slot];
							found = {found, tr};
						end
						usage_tab[id][slot] = it.st;
					end
				end
			end
			default: begin
			end
		endcase
		if (emit) begin
			for (i = 0; i < found.size(); i++) begin
				tr = found[i];
				tr.last = (i == found.size() - 1);
				pending_transitions = {pending_transitions, tr};
			end
		end
	endfunction

	// present one item, with random gaps ahead of it, and wait for the transaction
	task automatic issue(input item_t it, input bit emit);
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		op <= it.op;
		resource_id <= it.rid;
		subresource <= it.sub;
		all_subresources <= it.whole;
		usage_state <= it.st;
		subresource_count <= it.cnt;
		pass_number <= it.pass;
		queue_kind <= it.queue;
		do @(posedge clk); while (busy !== 1'b0);
		predict_transitions(it, emit);
	endtask

	// random items: mostly defines and uses of live ids, some clears and noise
	task automatic random_phase(input int n_items);
		item_t it;
		int    done;
		int    pick;
		done = 0;
		while (done < n_items) begin
			pick = $urandom_range(99);
			it.rid = 8'($urandom);
			it.sub = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(MAX_SUB - 1));
			it.whole = ($urandom_range(99) < 40);
			it.st = ($urandom_range(9) == 0) ? $urandom : state_pool[$urandom_range(3)];
			it.cnt = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(MAX_SUB));
			it.pass = 16'($urandom);
			it.queue = 2'($urandom);
			if (pick < 3) begin
				it.op = ssbt_pkg::OP_CLEAR;
			end else if (pick < 6) begin
				it.op = OP_IDLE;
			end else if (pick < 25 || defined_cnt == 0) begin
				it.op = ssbt_pkg::OP_DEFINE;
			end else begin
				it.op = ssbt_pkg::OP_USE;
				if ($urandom_range(9) != 0) it.rid = 8'($urandom_range(defined_cnt - 1));
			end
			if (it.op == ssbt_pkg::OP_DEFINE || it.op == ssbt_pkg::OP_CLEAR
					|| (it.op == ssbt_pkg::OP_USE && int'(it.rid) < defined_cnt)) begin
				done++;
			end
			issue(it, 1'b1);
		end
	endtask

	// compare each result against the oldest expected transition
	always @(posedge clk) begin
		transition_t want;
		if (result_valid === 1'b1) begin
			if (pending_transitions.size() == 0) begin
				report_mismatch($sformatf("unexpected transaction, resource %0d sub %0d",
					barrier_resource, barrier_subresource));
			end else begin
				want = pending_transitions.pop_front();
				check_field("barrier_pass", 32'(barrier_pass), 32'(want.pass));
				check_field("barrier_queue", 32'(barrier_queue), 32'(want.queue));
				check_field("barrier_resource", 32'(barrier_resource), 32'(want.res));
				check_field("barrier_subresource", 32'(barrier_subresource),
					32'(want.sub));
				check_field("barrier_whole", 32'(barrier_whole), 32'(want.whole));
				check_field("state_before", state_before, want.st_old);
				check_field("state_after", state_after, want.st_new);
				check_field("last", 32'(last), 32'(want.last));
			end
		end
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if ((start === 1'b1 && busy === 1'b0) || result_valid === 1'b1) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles == STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		item_t it;
		int    row;
		mismatches = 0;
		stall_cycles = 0;
		defined_cnt = 0;
		gap_pct = 32;
		state_pool[0] = '0;
		state_pool[1] = '1;
		state_pool[2] = $urandom;
		state_pool[3] = $urandom;
		arst_n <= 1'b0;
		start <= 1'b0;
		op <= ssbt_pkg::OP_DEFINE;
		resource_id <= '0;
		subresource <= '0;
		all_subresources <= 1'b0;
		usage_state <= '0;
		subresource_count <= '0;
		pass_number <= '0;
		queue_kind <= '0;

		// directed items: extremes, clamping, uniform and mixed whole uses, clear
		dir_tab = '{
			// use before anything is defined
			'{'{ssbt_pkg::OP_USE, 8'd0, 16'd0, 1'b0, 32'h0, 16'd0, 16'd0, 2'd0}, 0, NO_T},
			// count 0 becomes 1, id field ignored
			'{'{ssbt_pkg::OP_DEFINE, 8'hFF, 16'd0, 1'b0, 32'h0, 16'd0, 16'd0, 2'd0}, 0, NO_T},
			'{'{ssbt_pkg::OP_DEFINE, 8'd0, 16'd0, 1'b0, 32'hFFFF_FFFF, 16'd16, 16'd0, 2'd0},
				0, NO_T},
			// count saturates at the maximum
			'{'{ssbt_pkg::OP_DEFINE, 8'd0, 16'd0, 1'b0, 32'hA5A5_A5A5, 16'hFFFF, 16'd0, 2'd0},
				0, NO_T},
			'{'{ssbt_pkg::OP_DEFINE, 8'd0, 16'd0, 1'b0, 32'h11, 16'd3, 16'd0, 2'd0}, 0, NO_T},
			// state already at target
			'{'{ssbt_pkg::OP_USE, 8'd0, 16'd0, 1'b0, 32'h0, 16'd0, 16'd1, 2'd1}, 0, NO_T},
			// index clamped to the only entry
			'{'{ssbt_pkg::OP_USE, 8'd0, 16'hFFFF, 1'b0, 32'hFFFF_FFFF, 16'd0, 16'hFFFF, 2'd3},
				1, '{16'hFFFF, 2'd3, 6'd0, 4'd0, 1'b0, 32'h0, 32'hFFFF_FFFF, 1'b1}},
			// uniform whole use
			'{'{ssbt_pkg::OP_USE, 8'd1, 16'd0, 1'b1, 32'h0, 16'd0, 16'd0, 2'd0}, 1,
				'{16'd0, 2'd0, 6'd1, 4'd0, 1'b1, 32'hFFFF_FFFF, 32'h0, 1'b1}},
			'{'{ssbt_pkg::OP_USE, 8'd1, 16'd0, 1'b1, 32'h0, 16'd0, 16'd2, 2'd2}, 0, NO_T},
			'{'{ssbt_pkg::OP_USE, 8'd2, 16'd5, 1'b0, 32'h5A5A_5A5A, 16'd0, 16'd3, 2'd1}, 1,
				'{16'd3, 2'd1, 6'd2, 4'd5, 1'b0, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b1}},
			'{'{ssbt_pkg::OP_USE, 8'd2, 16'd15, 1'b0, 32'h1, 16'd0, 16'd4, 2'd2},
				USE_MODEL, NO_T},
			'{'{ssbt_pkg::OP_USE, 8'd2, 16'd20, 1'b0, 32'h2, 16'd0, 16'd5, 2'd3},
				USE_MODEL, NO_T},
			// mixed whole use, two entries differ
			'{'{ssbt_pkg::OP_USE, 8'd2, 16'd0, 1'b1, 32'hA5A5_A5A5, 16'd0, 16'd6, 2'd0},
				USE_MODEL, NO_T},
			'{'{ssbt_pkg::OP_USE, 8'd2, 16'd3, 1'b0, 32'h3, 16'd0, 16'd7, 2'd1},
				USE_MODEL, NO_T},
			// mixed whole use, all sixteen entries differ
			'{'{ssbt_pkg::OP_USE, 8'd2, 16'd0, 1'b1, 32'h0, 16'd0, 16'd8, 2'd2},
				USE_MODEL, NO_T},
			'{'{ssbt_pkg::OP_USE, 8'd3, 16'd0, 1'b1, 32'h11, 16'd0, 16'd9, 2'd3}, 0, NO_T},
			// unknown ids
			'{'{ssbt_pkg::OP_USE, 8'hFF, 16'd0, 1'b0, 32'h1, 16'd0, 16'd10, 2'd0}, 0, NO_T},
			'{'{ssbt_pkg::OP_USE, 8'd4, 16'd0, 1'b1, 32'h1, 16'd0, 16'd11, 2'd1}, 0, NO_T},
			'{'{OP_IDLE, 8'hAA, 16'h5555, 1'b1, 32'hDEAD_BEEF, 16'h1234, 16'd12, 2'd2}, 0, NO_T},
			'{'{ssbt_pkg::OP_CLEAR, 8'd0, 16'd0, 1'b0, 32'h0, 16'd0, 16'd0, 2'd0}, 0, NO_T},
			'{'{ssbt_pkg::OP_USE, 8'd0, 16'd0, 1'b1, 32'h5, 16'd0, 16'd13, 2'd3}, 0, NO_T},
			'{'{ssbt_pkg::OP_DEFINE, 8'd0, 16'd0, 1'b0, 32'h7, 16'd1, 16'd0, 2'd0}, 0, NO_T},
			'{'{ssbt_pkg::OP_USE, 8'd0, 16'd0, 1'b1, 32'h8, 16'd0, 16'd14, 2'd0},
				USE_MODEL, NO_T}
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (row = 0; row < DIR_N; row++) begin
			issue(dir_tab[row].it, dir_tab[row].nexp == USE_MODEL);
			if (dir_tab[row].nexp > 0) begin
				pending_transitions = {pending_transitions, dir_tab[row].tr};
			end
		end

		random_phase(8);

		// heavy sender gaps; fill the table, overflow it, then random traffic
		gap_pct = 72;
		while (defined_cnt < MAX_RES) begin
			it = '0;
			it.op = ssbt_pkg::OP_DEFINE;
			it.rid = 8'($urandom);
			it.cnt = 16'($urandom_range(MAX_SUB));
			it.st = state_pool[$urandom_range(3)];
			issue(it, 1'b1);
		end
		repeat (2) begin
			it.cnt = 16'(MAX_SUB);
			issue(it, 1'b1);
		end
		random_phase(8);

		// back-to-back items
		gap_pct = 0;
		random_phase(8);
		start <= 1'b0;

		while (pending_transitions.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
